// ----- hdl/qrs_pkg.sv -----
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_WIDTH      = 48;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_ONE   = 2'd1,
        ST_TWO   = 2'd2,
        ST_DEGEN = 2'd3
    } t_status;

endpackage

// ----- hdl/qrs_div.sv -----
// Restoring divider, one quotient bit per register stage.
module qrs_div
    import qrs_pkg::*;
#(
    parameter int NUM_W = COEF_WIDTH_DEF + FRAC_BITS_DEF + 2,
    parameter int DEN_W = COEF_WIDTH_DEF + 1
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [NUM_W-1:0] r_num [0:NUM_W];
    logic [DEN_W-1:0] r_den [0:NUM_W];
    logic [DEN_W-1:0] r_rem [0:NUM_W];
    logic [NUM_W-1:0] r_quo [0:NUM_W];

    always_comb begin
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_rem[0] = '0;
        r_quo[0] = '0;
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0] n_trial;
        logic           n_fit;

        always_comb begin
            n_trial = {r_rem[k], r_num[k][NUM_W-1]};
            n_fit   = (n_trial >= {1'b0, r_den[k]});
        end

        always_ff @(posedge i_clk) begin
            r_num[k+1] <= r_num[k] << 1;
            r_den[k+1] <= r_den[k];
            r_rem[k+1] <= n_fit ? DEN_W'(n_trial - {1'b0, r_den[k]}) : n_trial[DEN_W-1:0];
            r_quo[k+1] <= {r_quo[k][NUM_W-2:0], n_fit};
        end
    end

    assign o_quo = r_quo[NUM_W];

endmodule

// ----- hdl/quadratic_root_solver_top.sv -----
// Real roots of a*x^2 + b*x + c. One coefficient beat may be started every
// cycle (busy never rises); each beat gives exactly one result beat, marked by
// o_strobe for one cycle. The receiver cannot stall and results come out in
// order. The pipeline passes through the bit-per-stage square root
// (COEF_WIDTH+FRAC_BITS+1 stages) and then two parallel bit-per-stage
// dividers (COEF_WIDTH+FRAC_BITS+2 stages). Status: 0 no real root, 1 double
// root, 2 two roots, 3 a is zero. Roots are signed with FRAC_BITS fraction
// bits, truncated toward zero, saturated to 48 bits, and zero unless status
// is 1 or 2. With two roots o_root_first is (-b - sqrt(d))/(2a).
module quadratic_root_solver_top
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [COEF_WIDTH-1:0] i_coef_a,
    input  logic signed [COEF_WIDTH-1:0] i_coef_b,
    input  logic signed [COEF_WIDTH-1:0] i_coef_c,
    output logic                        o_strobe,
    output logic [1:0]                  o_root_status,
    output logic signed [OUT_WIDTH-1:0] o_root_first,
    output logic signed [OUT_WIDTH-1:0] o_root_second
);

    localparam int W     = COEF_WIDTH;
    localparam int DW    = 2 * W + 2;              // discriminant magnitude
    localparam int RADW  = DW + 2 * FRAC_BITS;     // scaled radicand
    localparam int SB    = W + FRAC_BITS + 1;      // root bits = sqrt stages
    localparam int REMW  = SB + 2;
    localparam int BW    = W + FRAC_BITS + 1;      // -b * 2^F, signed
    localparam int NW    = W + FRAC_BITS + 3;      // signed numerator
    localparam int QW    = NW - 1;                 // numerator magnitude
    localparam int DENW  = W + 1;
    localparam int CW    = ((QW > OUT_WIDTH) ? QW : OUT_WIDTH) + 2;
    localparam int LAT   = 5 + SB + QW;
    localparam logic signed [CW-1:0] POS_LIM = (CW'(1) << (OUT_WIDTH - 1)) - CW'(1);
    localparam logic signed [CW-1:0] NEG_LIM = -(CW'(1) << (OUT_WIDTH - 1));

    typedef struct packed {
        t_status              st;
        logic signed [BW-1:0] base;
        logic [DENW-1:0]      den;
        logic                 den_neg;
    } t_side;

    typedef struct packed {
        t_status st;
        logic    neg1;
        logic    neg2;
    } t_tag;

    assign busy = 1'b0;

    // stage 1: capture
    logic                  r1_v;
    logic signed [W-1:0]   r1_a, r1_b, r1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
        r1_a <= i_coef_a;
        r1_b <= i_coef_b;
        r1_c <= i_coef_c;
    end

    // stage 2: products on magnitudes
    logic [W-1:0]   n_mag_a, n_mag_b, n_mag_c;
    logic           r2_v;
    logic [2*W-1:0] r2_bsq, r2_ac;
    logic           r2_sdiff, r2_czero, r2_azero;
    t_side          r2_side;

    always_comb begin
        n_mag_a = r1_a[W-1] ? W'(-r1_a) : W'(r1_a);
        n_mag_b = r1_b[W-1] ? W'(-r1_b) : W'(r1_b);
        n_mag_c = r1_c[W-1] ? W'(-r1_c) : W'(r1_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_bsq          <= n_mag_b * n_mag_b;
        r2_ac           <= n_mag_a * n_mag_c;
        r2_sdiff        <= r1_a[W-1] != r1_c[W-1];
        r2_czero        <= r1_c == '0;
        r2_azero        <= r1_a == '0;
        r2_side.st      <= ST_NONE;
        r2_side.base    <= (-(BW'(r1_b))) <<< FRAC_BITS;
        r2_side.den     <= {n_mag_a, 1'b0};
        r2_side.den_neg <= r1_a[W-1];
    end

    // stage 3: discriminant and status
    logic [DW-1:0] n_bsq, n_fac, n_disc;
    logic          n_neg;
    t_side         n_side;
    logic          r3_v;
    logic [DW-1:0] r3_disc;
    t_side         r3_side;

    always_comb begin
        n_bsq = DW'(r2_bsq);
        n_fac = DW'(r2_ac) << 2;
        n_neg = 1'b0;
        if (r2_sdiff || r2_czero) begin
            n_disc = n_bsq + n_fac;
        end else if (n_bsq >= n_fac) begin
            n_disc = n_bsq - n_fac;
        end else begin
            n_disc = n_fac - n_bsq;
            n_neg  = 1'b1;
        end
        n_side = r2_side;
        if (r2_azero) begin
            n_side.st = ST_DEGEN;
        end else if (n_neg) begin
            n_side.st = ST_NONE;
        end else if (n_disc == '0) begin
            n_side.st = ST_ONE;
        end else begin
            n_side.st = ST_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_disc <= n_disc;
        r3_side <= n_side;
    end

    // square root: one result bit per stage
    logic            r_sq_v    [0:SB];
    logic [RADW-1:0] r_sq_rad  [0:SB];
    logic [REMW-1:0] r_sq_rem  [0:SB];
    logic [SB-1:0]   r_sq_root [0:SB];
    t_side           r_sq_side [0:SB];

    always_comb begin
        r_sq_v[0]    = r3_v;
        r_sq_rad[0]  = RADW'(r3_disc) << (2 * FRAC_BITS);
        r_sq_rem[0]  = '0;
        r_sq_root[0] = '0;
        r_sq_side[0] = r3_side;
    end

    for (genvar k = 0; k < SB; k++) begin : g_sqrt
        logic [REMW-1:0] n_rem, n_trial;

        always_comb begin
            n_rem   = {r_sq_rem[k][REMW-3:0], r_sq_rad[k][RADW-1 -: 2]};
            n_trial = {r_sq_root[k], 2'b01};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            r_sq_rad[k+1]  <= r_sq_rad[k] << 2;
            r_sq_side[k+1] <= r_sq_side[k];
            if (n_rem >= n_trial) begin
                r_sq_rem[k+1]  <= n_rem - n_trial;
                r_sq_root[k+1] <= {r_sq_root[k][SB-2:0], 1'b1};
            end else begin
                r_sq_rem[k+1]  <= n_rem;
                r_sq_root[k+1] <= {r_sq_root[k][SB-2:0], 1'b0};
            end
        end
    end

    // numerators -b*2^F -/+ s, split into magnitude and quotient sign
    logic signed [NW-1:0] n_base, n_s, n_num1, n_num2;
    logic                 rn_v;
    t_tag                 rn_tag;
    logic [QW-1:0]        rn_mag1, rn_mag2;
    logic [DENW-1:0]      rn_den;

    always_comb begin
        n_base = NW'(r_sq_side[SB].base);
        n_s    = signed'({{(NW - SB){1'b0}}, r_sq_root[SB]});
        n_num1 = n_base - n_s;
        n_num2 = n_base + n_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rn_v <= 1'b0;
        end else begin
            rn_v <= r_sq_v[SB];
        end
        rn_tag.st   <= r_sq_side[SB].st;
        rn_tag.neg1 <= n_num1[NW-1] ^ r_sq_side[SB].den_neg;
        rn_tag.neg2 <= n_num2[NW-1] ^ r_sq_side[SB].den_neg;
        rn_mag1     <= n_num1[NW-1] ? QW'(-n_num1) : QW'(n_num1);
        rn_mag2     <= n_num2[NW-1] ? QW'(-n_num2) : QW'(n_num2);
        rn_den      <= r_sq_side[SB].den;
    end

    logic [QW-1:0] w_quo1, w_quo2;

    qrs_div #(.NUM_W(QW), .DEN_W(DENW)) u_div1 (
        .i_clk (i_clk),
        .i_num (rn_mag1),
        .i_den (rn_den),
        .o_quo (w_quo1)
    );

    qrs_div #(.NUM_W(QW), .DEN_W(DENW)) u_div2 (
        .i_clk (i_clk),
        .i_num (rn_mag2),
        .i_den (rn_den),
        .o_quo (w_quo2)
    );

    // side line matching the divider depth
    logic r_dv_v   [0:QW];
    t_tag r_dv_tag [0:QW];

    always_comb begin
        r_dv_v[0]   = rn_v;
        r_dv_tag[0] = rn_tag;
    end

    for (genvar k = 0; k < QW; k++) begin : g_tag
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            r_dv_tag[k+1] <= r_dv_tag[k];
        end
    end

    // sign, saturate, zero when no root
    logic signed [CW-1:0]        n_val1, n_val2;
    logic signed [OUT_WIDTH-1:0] n_out1, n_out2;
    logic                        n_has_root;
    t_tag                        n_tag;

    always_comb begin
        n_tag      = r_dv_tag[QW];
        n_has_root = (n_tag.st == ST_ONE) || (n_tag.st == ST_TWO);
        n_val1     = n_tag.neg1 ? -signed'(CW'(w_quo1)) : signed'(CW'(w_quo1));
        n_val2     = n_tag.neg2 ? -signed'(CW'(w_quo2)) : signed'(CW'(w_quo2));
        if (n_val1 > POS_LIM) begin
            n_out1 = OUT_WIDTH'(POS_LIM);
        end else if (n_val1 < NEG_LIM) begin
            n_out1 = OUT_WIDTH'(NEG_LIM);
        end else begin
            n_out1 = OUT_WIDTH'(n_val1);
        end
        if (n_val2 > POS_LIM) begin
            n_out2 = OUT_WIDTH'(POS_LIM);
        end else if (n_val2 < NEG_LIM) begin
            n_out2 = OUT_WIDTH'(NEG_LIM);
        end else begin
            n_out2 = OUT_WIDTH'(n_val2);
        end
        if (!n_has_root) begin
            n_out1 = '0;
            n_out2 = '0;
        end
    end

    logic                        r_out_v;
    t_status                     r_out_st;
    logic signed [OUT_WIDTH-1:0] r_out_1, r_out_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_dv_v[QW];
        end
        r_out_st <= n_tag.st;
        r_out_1  <= n_out1;
        r_out_2  <= n_out2;
    end

    assign o_strobe      = r_out_v;
    assign o_root_status = r_out_st;
    assign o_root_first  = r_out_1;
    assign o_root_second = r_out_2;

    // a zero a must come out flagged degenerate after the full latency
    a_degen_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_coef_a == '0) |-> ##LAT (o_strobe && o_root_status == ST_DEGEN))
        else $error("degenerate item lost or late");

    // no-root results carry zero roots
    a_zero_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_root_status == ST_NONE || o_root_status == ST_DEGEN))
        |-> (o_root_first == '0 && o_root_second == '0))
        else $error("roots not cleared");

    // a double root has equal fields
    a_double_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_root_status == ST_ONE) |-> (o_root_first == o_root_second))
        else $error("double root fields differ");

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    import qrs_pkg::*;

    localparam int CW        = COEF_WIDTH_DEF;
    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = 2 * CW + 2 * FB + 8;
    localparam int WDOG_MAX  = 4000;

    typedef struct packed {
        t_status                     status;
        logic signed [OUT_WIDTH-1:0] first;
        logic signed [OUT_WIDTH-1:0] second;
    } t_roots;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic signed [CW-1:0]         i_coef_a;
    logic signed [CW-1:0]         i_coef_b;
    logic signed [CW-1:0]         i_coef_c;
    logic                         o_strobe;
    logic [1:0]                   o_root_status;
    logic signed [OUT_WIDTH-1:0]  o_root_first;
    logic signed [OUT_WIDTH-1:0]  o_root_second;

    t_roots roots_due[$];
    int     err_count;
    int     quiet_cycles;
    bit     idle_on;

    quadratic_root_solver_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_coef_a      (i_coef_a),
        .i_coef_b      (i_coef_b),
        .i_coef_c      (i_coef_c),
        .o_strobe      (o_strobe),
        .o_root_status (o_root_status),
        .o_root_first  (o_root_first),
        .o_root_second (o_root_second)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Truncating divide toward zero, clamped to the 48-bit output range.
    function automatic logic signed [OUT_WIDTH-1:0] div_clamp(longint num, longint den);
        longint q;
        q = num / den;
        if (q > (64'sd1 <<< (OUT_WIDTH - 1)) - 1)
            q = (64'sd1 <<< (OUT_WIDTH - 1)) - 1;
        if (q < -(64'sd1 <<< (OUT_WIDTH - 1)))
            q = -(64'sd1 <<< (OUT_WIDTH - 1));
        return q[OUT_WIDTH-1:0];
    endfunction

    // Floor square root of a 128-bit value, bit by bit from the top.
    function automatic logic [63:0] floor_sqrt(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] cand;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = r | (64'd1 << i);
            if ({64'd0, cand} * {64'd0, cand} <= x)
                r = cand;
        end
        return r;
    endfunction

    function automatic t_roots solve_roots(logic signed [CW-1:0] a,
                                           logic signed [CW-1:0] b,
                                           logic signed [CW-1:0] c);
        t_roots      r;
        logic signed [127:0] disc;
        logic [63:0] s;
        longint      base;
        longint      den;
        r = '{status: ST_NONE, first: '0, second: '0};
        if (a == 0) begin
            r.status = ST_DEGEN;
            return r;
        end
        disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
        if (disc < 0)
            return r;
        base = -longint'(b) * (64'sd1 <<< FB);
        den  = 2 * longint'(a);
        if (disc == 0) begin
            r.status = ST_ONE;
            r.first  = div_clamp(base, den);
            r.second = r.first;
            return r;
        end
        s = floor_sqrt(128'(disc) << (2 * FB));
        r.status = ST_TWO;
        r.first  = div_clamp(base - longint'(s), den);
        r.second = div_clamp(base + longint'(s), den);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [OUT_WIDTH-1:0] got,
                                   logic [OUT_WIDTH-1:0] want);
        $display("MISMATCH %s: got %0d want %0d at %0t", what, $signed(got),
                 $signed(want), $time);
        err_count++;
    endtask

    // Present one coefficient beat and hold it until it is taken.
    task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                              logic signed [CW-1:0] c);
        int gap;
        if (idle_on && ($urandom_range(0, 5) == 0)) begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_coef_a <= a;
        i_coef_b <= b;
        i_coef_c <= c;
        do @(posedge i_clk); while (busy);
        roots_due.push_back(solve_roots(a, b, c));
    endtask

    task automatic drop_start();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: every strobe is a beat that must match the oldest prediction.
    always @(posedge i_clk) begin
        t_roots want;
        if (i_rst_n && o_strobe) begin
            if (roots_due.size() == 0) begin
                report_mismatch("unexpected beat, status", 48'(o_root_status), '0);
            end else begin
                want = roots_due.pop_front();
                if (o_root_status !== want.status)
                    report_mismatch("status", 48'(o_root_status), 48'(want.status));
                if (o_root_first !== want.first)
                    report_mismatch("root_first", o_root_first, want.first);
                if (o_root_second !== want.second)
                    report_mismatch("root_second", o_root_second, want.second);
            end
        end
    end

    // Watchdog: cycles with no beat moving on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_extremes();
        logic signed [CW-1:0] lim[5];
        lim = '{16'sh8000, 16'sh7fff, -16'sd1, 16'sd1, 16'sd0};
        foreach (lim[i])
            send_coefs(lim[i], lim[(i + 1) % 5], lim[(i + 3) % 5]);
        send_coefs(16'sh8000, 16'sh8000, 16'sh7fff);
        send_coefs(16'sh7fff, 16'sh8000, 16'sh8000);
        send_coefs(16'sh8000, 16'sh7fff, 16'sh8000);
        send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
    endtask

    task automatic test_special_cases();
        send_coefs(16'sd0, 16'sd5, -16'sd3);   // a zero: degenerate
        send_coefs(16'sd0, 16'sd0, 16'sd0);
        send_coefs(16'sd1, 16'sd0, 16'sd1);    // no real root
        send_coefs(-16'sd3, 16'sd1, -16'sd7);
        send_coefs(16'sd1, -16'sd2, 16'sd1);   // double root
        send_coefs(16'sd4, 16'sd4, 16'sd1);
        send_coefs(-16'sd1, 16'sd6, -16'sd9);
        send_coefs(16'sd1, 16'sd0, -16'sd2);   // two roots, irrational
        send_coefs(16'sd2, -16'sd3, 16'sd0);   // c zero
        send_coefs(-16'sd5, 16'sd7, 16'sd3);
    endtask

    task automatic wait_for_roots();
        drop_start();
        while (roots_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_random(int n);
        logic signed [CW-1:0] a, b, c;
        int k;
        for (int i = 0; i < n; i++) begin
            a = CW'($urandom); b = CW'($urandom); c = CW'($urandom);
            case ($urandom_range(0, 7))
                0: a = 0;
                1: begin
                    // double root: b = 2*k*a, c = k*k*a
                    a = CW'($signed(5'($urandom)));
                    k = int'($urandom_range(0, 20)) - 10;
                    b = CW'(2 * k * a);
                    c = CW'(k * k * a);
                end
                2: begin
                    a = CW'($signed(8'($urandom)));
                    b = CW'($signed(8'($urandom)));
                    c = CW'($signed(8'($urandom)));
                end
                default: ;
            endcase
            send_coefs(a, b, c);
        end
    endtask

    initial begin
        err_count = 0;
        idle_on   = 1'b1;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_coef_a  = '0;
        i_coef_b  = '0;
        i_coef_c  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_special_cases();
        wait_for_roots();            // sender holds off until all beats are back
        test_random(600);
        idle_on = 1'b0;              // closing stretch back to back
        test_random(200);
        wait_for_roots();
        repeat (LATENCY + 10) @(posedge i_clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/qrs_pkg.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver_top.sv
tb/sv/testbench.sv
